@@ hdl/sorted_table_binary_search_defines.svh @@
// Assertion macros shared by the sorted table search checker.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define STBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define STBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/stbs_pkg.sv @@
// Shared types, constants and helpers for the sorted table search block.
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = 10;
  localparam int COUNT_W     = 11;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] entry_index;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  wdata;
  } mem_req_t;

  // Clamp the programmed count to the table depth.
  function automatic logic [CNT_W-1:0] sat_count(input count_t c);
    if (32'(c) > 32'(TABLE_DEPTH)) begin
      return CNT_W'(TABLE_DEPTH);
    end
    return CNT_W'(c);
  endfunction

endpackage

`default_nettype wire

@@ hdl/stbs_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hdl/stbs_search.sv @@
// Search sequencer: issues table writes and binary-search probes, builds results.
`default_nettype none

module stbs_search (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire stbs_pkg::in_word_t          in_word,
  input  wire stbs_pkg::count_t            cfg_count,
  input  wire logic [stbs_pkg::KEY_W-1:0]  mem_rdata,
  output stbs_pkg::mem_req_t               mem_req,
  output logic                             busy,
  output logic                             out_strobe,
  output stbs_pkg::out_word_t              out_word
);
  import stbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINAL
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  always_comb begin
    logic [CNT_W-1:0] count_sat;
    logic [CNT_W-1:0] span;
    logic [CNT_W:0]   sum;

    count_sat     = sat_count(cfg_count);
    span          = '0;
    sum           = '0;
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_req.we    = 1'b0;
    mem_req.addr  = mid_r;
    mem_req.wdata = in_word.key;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_word.mode == MODE_LOAD) begin
            if (32'(in_word.entry_index) < 32'(TABLE_DEPTH)) begin
              mem_req.we   = 1'b1;
              mem_req.addr = ADDR_W'(in_word.entry_index);
            end
          end else begin
            key_nxt = in_word.key;
            if (count_sat == '0) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '0;
            end else begin
              lo_nxt       = '0;
              hi_nxt       = count_sat;
              mid_nxt      = ADDR_W'(count_sat >> 1);
              mem_req.addr = mid_nxt;
              state_nxt    = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        if (mem_rdata == key_r) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.found       = 1'b1;
          out_word_nxt.match_index = IDX_W'(mid_r);
          state_nxt                = ST_IDLE;
        end else begin
          if (mem_rdata > key_r) begin
            hi_nxt = CNT_W'(mid_r);
          end else begin
            lo_nxt = CNT_W'(mid_r);
          end
          span = hi_nxt - lo_nxt;
          if (span <= CNT_W'(1)) begin
            mid_nxt   = ADDR_W'(lo_nxt);
            state_nxt = ST_FINAL;
          end else begin
            sum     = {1'b0, lo_nxt} + {1'b0, hi_nxt};
            mid_nxt = ADDR_W'(sum >> 1);
          end
          mem_req.addr = mid_nxt;
        end
      end
      ST_FINAL: begin
        out_valid_nxt            = 1'b1;
        out_word_nxt.found       = (mem_rdata == key_r);
        out_word_nxt.match_index = (mem_rdata == key_r) ? IDX_W'(mid_r) : '0;
        state_nxt                = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

@@ hdl/sorted_table_binary_search.sv @@
// Top level of the sorted key table with binary-search lookup.
// Load word: written to the table in the accept cycle; busy stays low, next word next cycle.
// Lookup word: one table probe per cycle; result strobe in the cycle after accept for an empty
//   table, else once a probe matches in ST_PROBE or after the final compare in ST_FINAL;
//   busy drops with the strobe.
// Probe rate is set by the single-port key RAM and its registered read data.
// Synchronous active-low reset clears the sequencer, the strobe and entry_count; table undefined.
`default_nettype none

module sorted_table_binary_search (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command channel
  input  wire logic                start,
  input  wire stbs_pkg::in_word_t  in_word,
  output logic                     busy,
  // result channel: one-cycle strobe, never stalled
  output logic                     out_strobe,
  output stbs_pkg::out_word_t      out_word,
  // configuration: entry_count
  input  wire logic                cfg_we,
  input  wire stbs_pkg::count_t    cfg_wdata
);
  import stbs_pkg::*;

  count_t           cfg_count_r;
  mem_req_t         mem_req;
  logic [KEY_W-1:0] mem_rdata;

  // Hold entry_count; software must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_we) begin
      cfg_count_r <= cfg_wdata;
    end
  end

  // Key table: written by load words, read once per search step.
  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // Sequencer: narrows [lo, hi) each cycle against the registered probe data.
  stbs_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_word    (in_word),
    .cfg_count  (cfg_count_r),
    .mem_rdata  (mem_rdata),
    .mem_req    (mem_req),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

@@ hdl/stbs_checker.sv @@
// Port-level assertions for the sorted table search block, bound to the top level.
`default_nettype none
`include "sorted_table_binary_search_defines.svh"

module stbs_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire stbs_pkg::in_word_t  in_word,
  input wire logic                busy,
  input wire logic                out_strobe,
  input wire stbs_pkg::out_word_t out_word
);
  import stbs_pkg::*;

  `STBS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!busy && !out_strobe), "busy or strobe after reset")
  `STBS_ASSERT(a_load_no_busy, (start && !busy && (in_word.mode == MODE_LOAD)) |=> !busy, "load word raised busy")
  `STBS_ASSERT(a_miss_zero_index, (out_strobe && !out_word.found) |-> (out_word.match_index == '0), "miss with nonzero index")
  `STBS_ASSERT(a_done_strobes, ($fell(busy) && $past(rst_n)) |-> out_strobe, "search ended without result")
  `STBS_ASSERT(a_strobe_cause, out_strobe |-> ($past(busy) || ($past(start) && $past(in_word.mode) == MODE_LOOKUP)), "result without lookup")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .in_word    (in_word),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

`default_nettype wire

@@ verif/tb_sorted_table_binary_search.sv @@
// Self-checking testbench for the sorted key table with binary-search lookup.
module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_word_t  in_word;
  logic      busy;
  logic      out_strobe;
  out_word_t out_word;
  logic      cfg_we;
  count_t    cfg_wdata;

  sorted_table_binary_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_word    (in_word),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the key table and of entry_count, plus a mark for every
  // entry ever loaded; a lookup whose search would touch an unloaded entry
  // is never sent.
  bit [KEY_W-1:0] key_table [TABLE_DEPTH];
  bit             loaded_q  [TABLE_DEPTH];
  count_t         entry_count_q;

  // Lookup answers still owed by the block, oldest first.
  out_word_t      pending_results [$];
  out_word_t      oldest_result;
  int unsigned    fail_count;

  // Chance in percent that the sender idles on a given cycle.
  int unsigned    idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run the same halving steps as the block: interval [lo, hi), probe the
  // midpoint, narrow, and compare the start entry once the span is one.
  function automatic out_word_t search_table(input logic [KEY_W-1:0] k);
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    out_word_t   r;
    r = '0;
    // Clamp an oversized count to the table depth.
    span = (int'(entry_count_q) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
    if (span == 0) begin
      return r;
    end
    lo = 0;
    hi = span;
    while (hi > lo) begin
      mid = (lo + hi) >> 1;
      if (key_table[mid] == k) begin
        r.found       = 1'b1;
        r.match_index = IDX_W'(mid);
        return r;
      end
      if (key_table[mid] > k) begin
        hi = mid;
      end else begin
        lo = mid;
      end
      if (hi - lo <= 1) begin
        if (key_table[lo] == k) begin
          r.found       = 1'b1;
          r.match_index = IDX_W'(lo);
        end
        return r;
      end
    end
    return r;
  endfunction

  // Walk the same steps and tell whether every entry probed was loaded.
  function automatic bit path_loaded(input logic [KEY_W-1:0] k);
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    span = (int'(entry_count_q) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
    if (span == 0) begin
      return 1'b1;
    end
    lo = 0;
    hi = span;
    while (hi > lo) begin
      mid = (lo + hi) >> 1;
      if (!loaded_q[mid]) begin
        return 1'b0;
      end
      if (key_table[mid] == k) begin
        return 1'b1;
      end
      if (key_table[mid] > k) begin
        hi = mid;
      end else begin
        lo = mid;
      end
      if (hi - lo <= 1) begin
        return loaded_q[lo];
      end
    end
    return 1'b1;
  endfunction

  // Ascending ramp used for the full-depth table: entry i holds i << 22,
  // the last entry all ones.
  function automatic logic [KEY_W-1:0] ramp_key(input int unsigned i);
    return (i == TABLE_DEPTH - 1) ? '1 : KEY_W'(i) << 22;
  endfunction

  // Present one word, hold it until the block takes it, then update the
  // shadow state and maybe idle for a few cycles.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    if (w.mode == MODE_LOOKUP) begin
      pending_results.push_back(search_table(w.key));
    end else begin
      key_table[w.entry_index] = w.key;
      loaded_q[w.entry_index]  = 1'b1;
    end
    gap = 0;
    while ($urandom_range(99, 0) < idle_pct) begin
      gap++;
    end
    // Keep start high when there is no gap so back-to-back words stay legal.
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] k);
    in_word_t w;
    w.mode        = MODE_LOAD;
    w.entry_index = idx;
    w.key         = k;
    send_word(w);
  endtask

  // Load the ramp entries that a full-depth search for k probes.
  task automatic load_path(input logic [KEY_W-1:0] k);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = TABLE_DEPTH;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (!loaded_q[mid]) begin
        load_entry(IDX_W'(mid), ramp_key(mid));
      end
      if (ramp_key(mid) == k) begin
        return;
      end
      if (ramp_key(mid) > k) begin
        hi = mid;
      end else begin
        lo = mid;
      end
    end
    if (!loaded_q[lo]) begin
      load_entry(IDX_W'(lo), ramp_key(lo));
    end
  endtask

  // Drop the lookup when its search would read an entry never loaded.
  task automatic lookup_key(input logic [KEY_W-1:0] k);
    in_word_t w;
    if (!path_loaded(k)) begin
      return;
    end
    w.mode        = MODE_LOOKUP;
    w.entry_index = IDX_W'($urandom_range(TABLE_DEPTH - 1, 0));
    w.key         = k;
    send_word(w);
  endtask

  // Drop start and hold off until every owed answer has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write entry_count only while idle; loads give no answer, so also wait
  // out the longest lookup latency before the write.
  task automatic write_count(input count_t v);
    wait_drained();
    repeat (14) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we        <= 1'b0;
    entry_count_q  = v;
  endtask

  // Check every strobed answer against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected answer: found=%0b index=%0d", $time,
                 out_word.found, out_word.match_index);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_word.found !== oldest_result.found ||
            out_word.match_index !== oldest_result.match_index) begin
          $display("%0t mismatch: expected found=%0b index=%0d, actual found=%0b index=%0d",
                   $time, oldest_result.found, oldest_result.match_index,
                   out_word.found, out_word.match_index);
          fail_count++;
        end
      end
    end
  end

  // Reset leaves entry_count at zero: lookups must miss without touching
  // the table. Then program zero explicitly and try again.
  task automatic test_empty_table();
    lookup_key('0);
    lookup_key('1);
    write_count('0);
    lookup_key(32'h1234_5678);
  endtask

  // Load the ascending ramp along the search paths of the probe keys, first
  // key zero and last all ones, then probe first, last, middle and gaps with
  // the full count.
  task automatic test_full_table();
    load_path('0);
    load_path('1);
    load_path(32'd512 << 22);
    load_path(32'd300 << 22);
    load_path(32'd1);
    load_path(32'hFFFF_FFFE);
    write_count(COUNT_W'(TABLE_DEPTH));
    lookup_key('0);
    lookup_key('1);
    lookup_key(32'd512 << 22);
    lookup_key(32'd300 << 22);
    lookup_key(32'd1);
    lookup_key(32'hFFFF_FFFE);
  endtask

  // Saturated count, and the shortest intervals of one and two entries.
  task automatic test_count_edges();
    load_path(32'd5 << 22);
    write_count('1);
    lookup_key('1);
    lookup_key(32'd5 << 22);
    write_count(COUNT_W'(1));
    lookup_key('0);
    lookup_key(32'd1 << 22);
    write_count(COUNT_W'(2));
    lookup_key(32'd1 << 22);
    lookup_key(32'd2 << 22);
  endtask

  // Descending keys: the search still runs its steps and must end.
  task automatic test_unsorted_table();
    int unsigned i;
    for (i = 0; i < 8; i++) begin
      load_entry(IDX_W'(i), KEY_W'(8 - i) << 24 | KEY_W'($urandom_range(255, 0)));
    end
    write_count(COUNT_W'(8));
    lookup_key(key_table[0]);
    lookup_key(key_table[3]);
    lookup_key(key_table[7]);
    lookup_key($urandom);
  endtask

  // Rounds of: load a fresh ascending run, program a count, then a stream of
  // lookups with some stray loads mixed in as noise.
  task automatic test_random_traffic(input int unsigned pct, input int unsigned budget);
    int unsigned sent;
    int unsigned n;
    int unsigned i;
    int unsigned lookups;
    int unsigned span;
    int unsigned pick;
    logic [KEY_W-1:0] step_max;
    logic [KEY_W-1:0] cur;
    idle_pct = pct;
    sent     = 0;
    while (sent < budget) begin
      // Mostly short tables, now and then a longer one.
      n        = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 65) : $urandom_range(64, 1);
      step_max = 32'hFFFF_FFFF / (n + 1);
      cur      = '0;
      for (i = 0; i < n; i++) begin
        cur = cur + $urandom_range(step_max, 0);
        load_entry(IDX_W'(i), cur);
      end
      sent += n;
      case ($urandom_range(9, 0))
        0:       write_count('0);
        1:       write_count(COUNT_W'(n - 1));
        2:       write_count(COUNT_W'($urandom_range(2047, TABLE_DEPTH + 1)));
        default: write_count(COUNT_W'(n));
      endcase
      span    = (int'(entry_count_q) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
      lookups = $urandom_range(40, 10);
      for (i = 0; i < lookups; i++) begin
        pick = $urandom_range(99, 0);
        if (pick < 10) begin
          // Stray load anywhere; it may break the ordering on purpose.
          load_entry(IDX_W'($urandom_range(TABLE_DEPTH - 1, 0)), $urandom);
        end else if (pick < 60 && span != 0) begin
          lookup_key(key_table[$urandom_range(span - 1, 0)]);
        end else if (pick < 80 && span != 0) begin
          // Near miss just above or below a stored key.
          lookup_key(key_table[$urandom_range(span - 1, 0)] +
                     (($urandom_range(1, 0) == 0) ? 32'd1 : 32'hFFFF_FFFF));
        end else if (pick < 85) begin
          lookup_key(($urandom_range(1, 0) == 0) ? '0 : '1);
        end else begin
          lookup_key($urandom);
        end
        // Now and then hold the sender until the block has fully drained.
        if ($urandom_range(39, 0) == 0) begin
          wait_drained();
        end
      end
      sent += lookups;
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_word       <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    entry_count_q  = '0;
    fail_count     = 0;
    idle_pct       = 23;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_full_table();
    test_count_edges();
    test_unsorted_table();
    test_random_traffic(23, 260);
    test_random_traffic(82, 260);
    test_random_traffic(0, 260);

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule.
  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
